// File: sv/fmrc_pkg.sv
// Shared types and constants for the factor-model residual cokurtosis core.
// Used by fmrc_outbuf and factor_model_residual_cokurtosis_core.
// No dependencies.
`default_nettype none

package fmrc_pkg;

    // Table geometry
    localparam int MAX_ASSETS = 16;
    localparam int IDX_W      = $clog2(MAX_ASSETS);
    localparam int COV_DEPTH  = MAX_ASSETS * MAX_ASSETS;
    localparam int COV_AW     = 2 * IDX_W;

    // Field widths
    localparam int OP_W    = 2;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 5;
    localparam int PROD_W  = 64;
    localparam int ACC_W   = 68;
    localparam int POS_W   = 16;
    localparam int POS_T_W = IDX_W + CFG_W;
    localparam int POS_U_W = POS_T_W + CFG_W;

    // Stream widths
    localparam int S_TDATA_W = 4 * IDX_W + 3 * VAL_W;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = PROD_W + POS_W;
    localparam int M_TUSER_W = 2;

    localparam logic [CFG_W-1:0] ASSET_COUNT_RESET = CFG_W'(MAX_ASSETS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD_MOMENT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_COV    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

    // Term weights
    localparam int ALL_EQUAL_WEIGHT   = 6;
    localparam int THREE_EQUAL_WEIGHT = 3;

    // Index equality pattern of a compute item
    typedef enum logic [2:0] {
        PAT_NONE     = 3'd0,
        PAT_ALL      = 3'd1,
        PAT_THREE    = 3'd2,
        PAT_TWO_PAIR = 3'd3,
        PAT_ONE_PAIR = 3'd4
    } t_pattern;

    // One result item
    typedef struct packed {
        logic                    saturated;
        logic                    index_error;
        logic [POS_W-1:0]        flat_position;
        logic signed [PROD_W-1:0] element_value;
    } t_result;

endpackage

`default_nettype wire

// File: sv/fmrc_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module fmrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// File: sv/fmrc_outbuf.sv
// Output register with skid stage: decouples the pipeline from the receiver.
// Depends on fmrc_pkg (t_result).
`default_nettype none

module fmrc_outbuf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_up_valid,
    output logic                  o_up_ready,
    input  wire fmrc_pkg::t_result i_up_item,
    output logic                  o_dn_valid,
    input  wire logic             i_dn_ready,
    output fmrc_pkg::t_result     o_dn_item
);

    logic              r_out_valid;
    logic              r_skid_valid;
    fmrc_pkg::t_result r_out;
    fmrc_pkg::t_result r_skid;
    logic              n_out_valid;
    logic              n_skid_valid;
    logic              w_load_out;
    logic              w_load_skid;
    logic              w_from_skid;

    // next-state of the two slots
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        w_load_out   = 1'b0;
        w_load_skid  = 1'b0;
        w_from_skid  = 1'b0;
        if (r_skid_valid) begin
            if (i_dn_ready) begin
                w_load_out   = 1'b1;
                w_from_skid  = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (i_up_valid) begin
            if (!r_out_valid || i_dn_ready) begin
                w_load_out  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                w_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end else if (i_dn_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload slots
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_from_skid ? r_skid : i_up_item;
        end
        if (w_load_skid) begin
            r_skid <= i_up_item;
        end
    end

    assign o_up_ready = !r_skid_valid;
    assign o_dn_valid = r_out_valid;
    assign o_dn_item  = r_out;

endmodule

`default_nettype wire

// File: sv/factor_model_residual_cokurtosis_core.sv
// Factor-model residual cokurtosis core: top level.
// Depends on fmrc_pkg, fmrc_ram and fmrc_outbuf.
//
// Usage:
//   s_axis carries one item per handshake. tuser selects the operation:
//   moment load, covariance load or compute. Loads write the moment tables
//   or the covariance table at the acceptance edge and give no result;
//   a compute item gives exactly one result item on m_axis.
//   The config channel writes asset_count; ready is always high. The user
//   must write it only while no item is in flight; the block does not enforce this.
//   Throughput: one item per cycle while m_axis is not stalled, set by the
//   single read of each table per item and a fully pipelined datapath
//   (table read, multiply, weighting, sum and saturate, output register).
//   m_axis_tvalid rises after the stage 1 to 4 registers and the output register.
//   Reset clears all valid bits and sets asset_count to 16; table
//   contents are undefined until loaded.
//   When the receiver stalls, a skid stage takes one more result, then
//   s_axis_tready falls and the whole pipeline holds; nothing is lost.
`default_nettype none

module factor_model_residual_cokurtosis_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config: asset_count
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [fmrc_pkg::CFG_W-1:0]       i_cfg_data,
    // tdata: index_i, index_j, index_k, index_l, second_moment_value,
    //        fourth_moment_value, covariance_value (lowest first)
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [fmrc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: operation
    input  wire logic [fmrc_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // tdata: element_value, flat_position (lowest first)
    output logic      [fmrc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: index_error, saturated (lowest first)
    output logic      [fmrc_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    localparam int IW = fmrc_pkg::IDX_W;
    localparam int VW = fmrc_pkg::VAL_W;
    localparam int CW = fmrc_pkg::CFG_W;
    localparam int AW = fmrc_pkg::ACC_W;
    localparam int PW = fmrc_pkg::PROD_W;

    // ---------------- config ----------------
    logic [CW-1:0] r_asset_count;
    logic [CW-1:0] w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asset_count <= fmrc_pkg::ASSET_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_asset_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_n = (r_asset_count > CW'(fmrc_pkg::MAX_ASSETS)) ?
                 CW'(fmrc_pkg::MAX_ASSETS) : r_asset_count;

    // ---------------- input unpack ----------------
    logic                  w_en;
    logic                  w_accept;
    logic [fmrc_pkg::OP_W-1:0] w_op;
    logic [IW-1:0]         w_i, w_j, w_k, w_l;
    logic [VW-1:0]         w_m2_in, w_m4_in, w_cov_in;

    assign w_op     = s_axis_tuser;
    assign w_i      = s_axis_tdata[IW-1:0];
    assign w_j      = s_axis_tdata[2*IW-1:IW];
    assign w_k      = s_axis_tdata[3*IW-1:2*IW];
    assign w_l      = s_axis_tdata[4*IW-1:3*IW];
    assign w_m2_in  = s_axis_tdata[4*IW+VW-1:4*IW];
    assign w_m4_in  = s_axis_tdata[4*IW+2*VW-1:4*IW+VW];
    assign w_cov_in = s_axis_tdata[4*IW+3*VW-1:4*IW+2*VW];

    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && w_en;

    // ---------------- stage 0: range check, pattern, table addresses -----
    logic w_i_ok, w_j_ok, w_k_ok, w_l_ok, w_err;
    logic w_eq_ij, w_eq_ik, w_eq_il, w_eq_jk, w_eq_jl, w_eq_kl;
    logic w_m2_we, w_cov_we;
    fmrc_pkg::t_pattern w_pattern;
    logic [IW-1:0] w_cov_a_row, w_cov_a_col, w_cov_b_row, w_cov_b_col;
    logic [IW-1:0] w_m2_a_addr, w_m2_b_addr;

    assign w_i_ok = {1'b0, w_i} < w_n;
    assign w_j_ok = {1'b0, w_j} < w_n;
    assign w_k_ok = {1'b0, w_k} < w_n;
    assign w_l_ok = {1'b0, w_l} < w_n;
    assign w_err  = !(w_i_ok && w_j_ok && w_k_ok && w_l_ok);

    assign w_m2_we  = w_accept && (w_op == fmrc_pkg::OP_LOAD_MOMENT) && w_i_ok;
    assign w_cov_we = w_accept && (w_op == fmrc_pkg::OP_LOAD_COV) && w_i_ok && w_j_ok;

    assign w_eq_ij = (w_i == w_j);
    assign w_eq_ik = (w_i == w_k);
    assign w_eq_il = (w_i == w_l);
    assign w_eq_jk = (w_j == w_k);
    assign w_eq_jl = (w_j == w_l);
    assign w_eq_kl = (w_k == w_l);

    // pattern classification in model priority order
    always_comb begin
        w_pattern   = fmrc_pkg::PAT_NONE;
        w_cov_a_row = w_i;
        w_cov_a_col = w_i;
        w_cov_b_row = w_i;
        w_cov_b_col = w_i;
        w_m2_a_addr = w_i;
        w_m2_b_addr = w_i;
        if (w_eq_ij && w_eq_ik && w_eq_il) begin
            w_pattern = fmrc_pkg::PAT_ALL;
        end else if (w_eq_ij && w_eq_ik) begin
            w_pattern   = fmrc_pkg::PAT_THREE;
            w_cov_a_col = w_l;
        end else if (w_eq_ij && w_eq_il) begin
            w_pattern   = fmrc_pkg::PAT_THREE;
            w_cov_a_col = w_k;
        end else if (w_eq_ik && w_eq_il) begin
            w_pattern   = fmrc_pkg::PAT_THREE;
            w_cov_a_col = w_j;
        end else if (w_eq_jk && w_eq_jl) begin
            w_pattern   = fmrc_pkg::PAT_THREE;
            w_cov_a_row = w_j;
            w_cov_a_col = w_i;
            w_m2_a_addr = w_j;
        end else if (w_eq_ij && w_eq_kl) begin
            w_pattern   = fmrc_pkg::PAT_TWO_PAIR;
            w_m2_a_addr = w_k;
            w_cov_b_row = w_k;
            w_cov_b_col = w_k;
        end else if ((w_eq_ik && w_eq_jl) || (w_eq_il && w_eq_jk)) begin
            w_pattern   = fmrc_pkg::PAT_TWO_PAIR;
            w_m2_a_addr = w_j;
            w_cov_b_row = w_j;
            w_cov_b_col = w_j;
        end else if (w_eq_ij) begin
            w_pattern   = fmrc_pkg::PAT_ONE_PAIR;
            w_cov_a_row = w_k;
            w_cov_a_col = w_l;
        end else if (w_eq_ik) begin
            w_pattern   = fmrc_pkg::PAT_ONE_PAIR;
            w_cov_a_row = w_j;
            w_cov_a_col = w_l;
        end else if (w_eq_il) begin
            w_pattern   = fmrc_pkg::PAT_ONE_PAIR;
            w_cov_a_row = w_j;
            w_cov_a_col = w_k;
        end else if (w_eq_jk) begin
            w_pattern   = fmrc_pkg::PAT_ONE_PAIR;
            w_cov_a_col = w_l;
            w_m2_a_addr = w_j;
        end else if (w_eq_jl) begin
            w_pattern   = fmrc_pkg::PAT_ONE_PAIR;
            w_cov_a_col = w_k;
            w_m2_a_addr = w_j;
        end else if (w_eq_kl) begin
            w_pattern   = fmrc_pkg::PAT_ONE_PAIR;
            w_cov_a_col = w_j;
            w_m2_a_addr = w_k;
        end
        // out-of-range tuple gives a zero element
        if (w_err) begin
            w_pattern = fmrc_pkg::PAT_NONE;
        end
    end

    // ---------------- tables (read data forms stage 1) ----------------
    logic [VW-1:0] w_m2_a, w_m2_b, w_m4, w_m4_unused, w_cov_a, w_cov_b;

    fmrc_ram #(.WIDTH(VW), .DEPTH(fmrc_pkg::MAX_ASSETS)) u_m2_ram (
        .i_clk     (i_clk),
        .i_we      (w_m2_we),
        .i_waddr   (w_i),
        .i_wdata   (w_m2_in),
        .i_re      (w_en),
        .i_raddr_a (w_m2_a_addr),
        .i_raddr_b (w_m2_b_addr),
        .o_rdata_a (w_m2_a),
        .o_rdata_b (w_m2_b)
    );

    fmrc_ram #(.WIDTH(VW), .DEPTH(fmrc_pkg::MAX_ASSETS)) u_m4_ram (
        .i_clk     (i_clk),
        .i_we      (w_m2_we),
        .i_waddr   (w_i),
        .i_wdata   (w_m4_in),
        .i_re      (w_en),
        .i_raddr_a (w_i),
        .i_raddr_b (w_i),
        .o_rdata_a (w_m4),
        .o_rdata_b (w_m4_unused)
    );

    fmrc_ram #(.WIDTH(VW), .DEPTH(fmrc_pkg::COV_DEPTH)) u_cov_ram (
        .i_clk     (i_clk),
        .i_we      (w_cov_we),
        .i_waddr   ({w_i, w_j}),
        .i_wdata   (w_cov_in),
        .i_re      (w_en),
        .i_raddr_a ({w_cov_a_row, w_cov_a_col}),
        .i_raddr_b ({w_cov_b_row, w_cov_b_col}),
        .o_rdata_a (w_cov_a),
        .o_rdata_b (w_cov_b)
    );

    // ---------------- stage 1 registers ----------------
    logic               r1_valid;
    fmrc_pkg::t_pattern r1_pattern;
    logic               r1_err;
    logic [IW-1:0]      r1_i, r1_j, r1_k, r1_l;
    logic [CW-1:0]      r1_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= w_accept && (w_op == fmrc_pkg::OP_COMPUTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pattern <= w_pattern;
            r1_err     <= w_err;
            r1_i       <= w_i;
            r1_j       <= w_j;
            r1_k       <= w_k;
            r1_l       <= w_l;
            r1_n       <= w_n;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [PW:0]   w_mul_a, w_mul_b;
    logic        [PW-1:0] w_mul_m;
    logic [fmrc_pkg::POS_T_W-1:0] w_pos_t;

    assign w_mul_a = $signed(w_cov_a) * $signed({1'b0, w_m2_a});
    assign w_mul_b = $signed(w_cov_b) * $signed({1'b0, w_m2_b});
    assign w_mul_m = {{VW{1'b0}}, w_m2_a} * {{VW{1'b0}}, w_m2_b};
    // i*N + j
    assign w_pos_t = {{CW{1'b0}}, r1_i} * {{IW{1'b0}}, r1_n}
                   + {{CW{1'b0}}, r1_j};

    logic                  r2_valid;
    fmrc_pkg::t_pattern    r2_pattern;
    logic                  r2_err;
    logic signed [PW-1:0]  r2_prod_a, r2_prod_b;
    logic        [PW-1:0]  r2_prod_m;
    logic        [VW-1:0]  r2_m4;
    logic [fmrc_pkg::POS_T_W-1:0] r2_pos_t;
    logic [IW-1:0]         r2_k, r2_l;
    logic [CW-1:0]         r2_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pattern <= r1_pattern;
            r2_err     <= r1_err;
            r2_prod_a  <= $signed(w_mul_a[PW-1:0]);
            r2_prod_b  <= $signed(w_mul_b[PW-1:0]);
            r2_prod_m  <= w_mul_m;
            r2_m4      <= w_m4;
            r2_pos_t   <= w_pos_t;
            r2_k       <= r1_k;
            r2_l       <= r1_l;
            r2_n       <= r1_n;
        end
    end

    // ---------------- stage 3: weighting ----------------
    logic signed [AW-1:0] w_pa, w_pb, w_op_x, w_op_y, w_term;
    logic        [PW-1:0] w_extra;
    logic [fmrc_pkg::POS_U_W-1:0] w_pos_u;

    assign w_pa = {{(AW-PW){r2_prod_a[PW-1]}}, r2_prod_a};
    assign w_pb = {{(AW-PW){r2_prod_b[PW-1]}}, r2_prod_b};

    // 6x = 4x + 2x, 3x = 2x + x
    always_comb begin
        w_op_x  = '0;
        w_op_y  = '0;
        w_extra = '0;
        case (r2_pattern)
            fmrc_pkg::PAT_ALL: begin
                w_op_x  = w_pa <<< 2;
                w_op_y  = w_pa <<< 1;
                w_extra = {{(PW-VW-16){1'b0}}, r2_m4, 16'h0000};
            end
            fmrc_pkg::PAT_THREE: begin
                w_op_x = w_pa <<< 1;
                w_op_y = w_pa;
            end
            fmrc_pkg::PAT_TWO_PAIR: begin
                w_op_x  = w_pa;
                w_op_y  = w_pb;
                w_extra = r2_prod_m;
            end
            fmrc_pkg::PAT_ONE_PAIR: begin
                w_op_x = w_pa;
            end
            default: begin
                w_op_x = '0;
            end
        endcase
    end

    assign w_term  = w_op_x + w_op_y;
    // (i*N + j)*N + l
    assign w_pos_u = {{CW{1'b0}}, r2_pos_t} * {{fmrc_pkg::POS_T_W{1'b0}}, r2_n}
                   + {{(fmrc_pkg::POS_U_W-IW){1'b0}}, r2_l};

    logic                 r3_valid;
    logic                 r3_err;
    logic signed [AW-1:0] r3_term;
    logic        [PW-1:0] r3_extra;
    logic [fmrc_pkg::POS_U_W-1:0] r3_pos_u;
    logic [IW-1:0]        r3_k;
    logic [CW-1:0]        r3_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_err   <= r2_err;
            r3_term  <= w_term;
            r3_extra <= w_extra;
            r3_pos_u <= w_pos_u;
            r3_k     <= r2_k;
            r3_n     <= r2_n;
        end
    end

    // ---------------- stage 4: final sum, saturation, position ---------
    logic signed [AW-1:0]  w_sum;
    logic                  w_fits;
    fmrc_pkg::t_result     w_result;
    logic [fmrc_pkg::POS_U_W+CW-1:0] w_pos_full;

    assign w_sum  = r3_term + $signed({{(AW-PW){1'b0}}, r3_extra});
    assign w_fits = (w_sum[AW-1:PW-1] == '0) || (w_sum[AW-1:PW-1] == '1);
    // ((i*N + j)*N + l)*N + k
    assign w_pos_full = {{CW{1'b0}}, r3_pos_u} * {{fmrc_pkg::POS_U_W{1'b0}}, r3_n}
                      + {{(fmrc_pkg::POS_U_W+CW-IW){1'b0}}, r3_k};

    always_comb begin
        w_result.index_error   = r3_err;
        w_result.flat_position = w_pos_full[fmrc_pkg::POS_W-1:0];
        w_result.saturated     = !w_fits;
        if (w_fits) begin
            w_result.element_value = w_sum[PW-1:0];
        end else if (w_sum[AW-1]) begin
            w_result.element_value = {1'b1, {(PW-1){1'b0}}};
        end else begin
            w_result.element_value = {1'b0, {(PW-1){1'b1}}};
        end
    end

    logic              r4_valid;
    fmrc_pkg::t_result r4_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_result <= w_result;
        end
    end

    // ---------------- output register and skid ----------------
    fmrc_pkg::t_result w_out_item;

    fmrc_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (r4_valid),
        .o_up_ready (w_en),
        .i_up_item  (r4_result),
        .o_dn_valid (m_axis_tvalid),
        .i_dn_ready (m_axis_tready),
        .o_dn_item  (w_out_item)
    );

    assign m_axis_tdata = {w_out_item.flat_position, w_out_item.element_value};
    assign m_axis_tuser = {w_out_item.saturated, w_out_item.index_error};

`ifndef SYNTH
    // flagged index forces a zero, unsaturated element
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[PW-1:0] == '0) && !m_axis_tuser[1])
        else $error("index error with nonzero element");

    // clipped value is exactly one of the Q32.32 bounds
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            (m_axis_tdata[PW-1:0] == {1'b0, {(PW-1){1'b1}}}) ||
            (m_axis_tdata[PW-1:0] == {1'b1, {(PW-1){1'b0}}}))
        else $error("saturated element not at a bound");

    // input back-pressure only while a result is held at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");
`endif

endmodule

`default_nettype wire
